// ----- rtl/hbk_pkg.sv -----
// hbk_pkg: constants, ROM entry type and the usage-to-set-1 ROM function for the
// HID boot keyboard to PS/2 set-1 translator. No dependencies.
package hbk_pkg;

  localparam int          NUM_MODS       = 8;
  localparam int          INPUT_KEYS     = 6;
  localparam int          ROM_BITS       = 9;
  localparam logic [6:0]  MIN_REPORT_LEN = 7'd8;
  localparam logic [7:0]  PREFIX_BYTE    = 8'hE0;
  localparam logic [7:0]  BREAK_BIT      = 8'h80;
  localparam logic [7:0]  MOD_USAGE_BASE = 8'hE0;
  localparam logic [7:0]  LAST_SPECIAL   = 8'h01;

  typedef struct packed {
    logic [7:0] code;
    logic       ext;
  } rom_entry_t;

  function automatic rom_entry_t usage_rom(input logic [7:0] usage);
    rom_entry_t e;
    e = '{code: 8'h00, ext: 1'b0};
    unique case (usage)
      8'h04: e.code = 8'h1E;  8'h05: e.code = 8'h30;  8'h06: e.code = 8'h2E;
      8'h07: e.code = 8'h20;  8'h08: e.code = 8'h12;  8'h09: e.code = 8'h21;
      8'h0A: e.code = 8'h22;  8'h0B: e.code = 8'h23;  8'h0C: e.code = 8'h17;
      8'h0D: e.code = 8'h24;  8'h0E: e.code = 8'h25;  8'h0F: e.code = 8'h26;
      8'h10: e.code = 8'h32;  8'h11: e.code = 8'h31;  8'h12: e.code = 8'h18;
      8'h13: e.code = 8'h19;  8'h14: e.code = 8'h10;  8'h15: e.code = 8'h13;
      8'h16: e.code = 8'h1F;  8'h17: e.code = 8'h14;  8'h18: e.code = 8'h16;
      8'h19: e.code = 8'h2F;  8'h1A: e.code = 8'h11;  8'h1B: e.code = 8'h2D;
      8'h1C: e.code = 8'h15;  8'h1D: e.code = 8'h2C;
      8'h1E: e.code = 8'h02;  8'h1F: e.code = 8'h03;  8'h20: e.code = 8'h04;
      8'h21: e.code = 8'h05;  8'h22: e.code = 8'h06;  8'h23: e.code = 8'h07;
      8'h24: e.code = 8'h08;  8'h25: e.code = 8'h09;  8'h26: e.code = 8'h0A;
      8'h27: e.code = 8'h0B;
      8'h28: e.code = 8'h1C;  8'h29: e.code = 8'h01;  8'h2A: e.code = 8'h0E;
      8'h2B: e.code = 8'h0F;  8'h2C: e.code = 8'h39;  8'h2D: e.code = 8'h0C;
      8'h2E: e.code = 8'h0D;  8'h2F: e.code = 8'h1A;  8'h30: e.code = 8'h1B;
      8'h31: e.code = 8'h2B;  8'h33: e.code = 8'h27;  8'h34: e.code = 8'h28;
      8'h35: e.code = 8'h29;  8'h36: e.code = 8'h33;  8'h37: e.code = 8'h34;
      8'h38: e.code = 8'h35;  8'h39: e.code = 8'h3A;
      8'h3A: e.code = 8'h3B;  8'h3B: e.code = 8'h3C;  8'h3C: e.code = 8'h3D;
      8'h3D: e.code = 8'h3E;  8'h3E: e.code = 8'h3F;  8'h3F: e.code = 8'h40;
      8'h40: e.code = 8'h41;  8'h41: e.code = 8'h42;  8'h42: e.code = 8'h43;
      8'h43: e.code = 8'h44;  8'h44: e.code = 8'h57;  8'h45: e.code = 8'h58;
      8'h47: e.code = 8'h46;
      8'h49: e = '{code: 8'h52, ext: 1'b1};
      8'h4A: e = '{code: 8'h47, ext: 1'b1};
      8'h4B: e = '{code: 8'h49, ext: 1'b1};
      8'h4C: e = '{code: 8'h53, ext: 1'b1};
      8'h4D: e = '{code: 8'h4F, ext: 1'b1};
      8'h4E: e = '{code: 8'h51, ext: 1'b1};
      8'h4F: e = '{code: 8'h4D, ext: 1'b1};
      8'h50: e = '{code: 8'h4B, ext: 1'b1};
      8'h51: e = '{code: 8'h50, ext: 1'b1};
      8'h52: e = '{code: 8'h48, ext: 1'b1};
      8'hE0: e.code = 8'h1D;
      8'hE1: e.code = 8'h2A;
      8'hE2: e.code = 8'h38;
      8'hE4: e = '{code: 8'h1D, ext: 1'b1};
      8'hE5: e.code = 8'h36;
      8'hE6: e = '{code: 8'h38, ext: 1'b1};
      default: e = '{code: 8'h00, ext: 1'b0};
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/hbk_if.sv -----
// hbk_in_if / hbk_out_if: valid-ready channels for keyboard reports and scancode bytes.
// No dependencies.
interface hbk_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] report_length;
  logic [7:0] modifier_bits;
  logic [7:0] key_code_0;
  logic [7:0] key_code_1;
  logic [7:0] key_code_2;
  logic [7:0] key_code_3;
  logic [7:0] key_code_4;
  logic [7:0] key_code_5;
  modport source (output valid, report_length, modifier_bits, key_code_0, key_code_1,
                  key_code_2, key_code_3, key_code_4, key_code_5, input ready);
  modport sink   (input valid, report_length, modifier_bits, key_code_0, key_code_1,
                  key_code_2, key_code_3, key_code_4, key_code_5, output ready);
endinterface

interface hbk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;
  logic       last_of_report;
  modport source (output valid, scan_byte, last_of_report, input ready);
  modport sink   (input valid, scan_byte, last_of_report, output ready);
endinterface

// ----- rtl/hid_boot_keyboard_to_ps2_set1.sv -----
// Translates USB HID boot keyboard reports into PS/2 scan code set 1 bytes:
// modifier changes first, then releases, then presses, with E0 prefixes and
// break codes, and last_of_report marking the final byte of each report.
// A report is taken whenever the two-entry report queue has room, so reports
// may arrive back to back. The byte sequencer loads a report and then sends its
// bytes one after another, stalling while the output is not ready, and takes the
// next report only once the current one is done; reports that are short or
// change nothing take no sequencer time. Depends on hbk_pkg, hbk_if and the
// hbk_front, hbk_queue and hbk_back modules.
module hid_boot_keyboard_to_ps2_set1 #(
  parameter int KEY_SLOTS = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  hbk_in_if.sink    in_ch,
  hbk_out_if.source out_ch
);
  import hbk_pkg::*;

  localparam int NUM_EVT = NUM_MODS + 2 * KEY_SLOTS;
  localparam int Q_W     = NUM_EVT * 11;

  logic                 f_valid;
  logic                 f_ready;
  logic [NUM_EVT-1:0]   f_mask;
  logic [NUM_EVT-1:0]   f_press;
  logic [NUM_EVT-1:0]   f_ext;
  logic [NUM_EVT*8-1:0] f_code;
  logic                 b_valid;
  logic                 b_ready;
  logic [Q_W-1:0]       q_rd;
  logic [Q_W-1:0]       q_wr;

  assign q_wr = {f_mask, f_press, f_ext, f_code};

  hbk_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .evt_mask   (f_mask),
    .evt_press  (f_press),
    .evt_ext    (f_ext),
    .evt_code   (f_code)
  );

  hbk_queue #(.WIDTH(Q_W)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (q_wr),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (q_rd)
  );

  hbk_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .evt_mask  (q_rd[Q_W-1 -: NUM_EVT]),
    .evt_press (q_rd[Q_W-NUM_EVT-1 -: NUM_EVT]),
    .evt_ext   (q_rd[NUM_EVT*8 +: NUM_EVT]),
    .evt_code  (q_rd[NUM_EVT*8-1:0]),
    .out_ch    (out_ch)
  );

endmodule

// ----- rtl/hbk_front.sv -----
// hbk_front: accepts reports, keeps previous modifiers and keys, and classifies
// each report into a mask of byte-producing events. Depends on hbk_pkg, hbk_if.
module hbk_front #(
  parameter  int KEY_SLOTS = 6,
  localparam int NUM_EVT   = 8 + 2 * KEY_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  hbk_in_if.sink             in_ch,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [NUM_EVT-1:0] evt_mask,
  output logic [NUM_EVT-1:0] evt_press,
  output logic [NUM_EVT-1:0] evt_ext,
  output logic [NUM_EVT*8-1:0] evt_code
);
  import hbk_pkg::*;

  logic [7:0] in_keys   [INPUT_KEYS];
  logic [7:0] now_keys  [KEY_SLOTS];
  logic [7:0] prev_keys_r [KEY_SLOTS];
  logic [7:0] prev_mods_r;
  logic [KEY_SLOTS-1:0] prev_hit;
  logic [KEY_SLOTS-1:0] now_hit;
  rom_entry_t rom_mod  [NUM_MODS];
  rom_entry_t rom_prev [KEY_SLOTS];
  rom_entry_t rom_now  [KEY_SLOTS];
  logic       len_ok;
  logic       accept;

  assign in_keys[0] = in_ch.key_code_0;
  assign in_keys[1] = in_ch.key_code_1;
  assign in_keys[2] = in_ch.key_code_2;
  assign in_keys[3] = in_ch.key_code_3;
  assign in_keys[4] = in_ch.key_code_4;
  assign in_keys[5] = in_ch.key_code_5;

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
    if (g < INPUT_KEYS) begin : g_real
      assign now_keys[g] = in_keys[g];
    end else begin : g_pad
      assign now_keys[g] = '0;
    end
  end

  assign len_ok       = (in_ch.report_length >= MIN_REPORT_LEN);
  assign in_ch.ready  = push_ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign push_valid   = in_ch.valid && len_ok && (|evt_mask);

  always_comb begin
    prev_hit = '0;
    now_hit  = '0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      for (int k = 0; k < KEY_SLOTS; k++) begin
        if (prev_keys_r[j] == now_keys[k]) prev_hit[j] = 1'b1;
        if (now_keys[j] == prev_keys_r[k]) now_hit[j] = 1'b1;
      end
    end
    for (int i = 0; i < NUM_MODS; i++) begin
      rom_mod[i]          = usage_rom(MOD_USAGE_BASE + 8'(i));
      evt_mask[i]         = (prev_mods_r[i] ^ in_ch.modifier_bits[i]) &&
                            (rom_mod[i].code != 8'h00);
      evt_press[i]        = in_ch.modifier_bits[i];
      evt_ext[i]          = rom_mod[i].ext;
      evt_code[8*i +: 8]  = rom_mod[i].code;
    end
    for (int j = 0; j < KEY_SLOTS; j++) begin
      rom_prev[j] = usage_rom(prev_keys_r[j]);
      rom_now[j]  = usage_rom(now_keys[j]);
      evt_mask[NUM_MODS + j]  = (prev_keys_r[j] > LAST_SPECIAL) && !prev_hit[j] &&
                                (rom_prev[j].code != 8'h00);
      evt_press[NUM_MODS + j] = 1'b0;
      evt_ext[NUM_MODS + j]   = rom_prev[j].ext;
      evt_code[8*(NUM_MODS + j) +: 8] = rom_prev[j].code;
      evt_mask[NUM_MODS + KEY_SLOTS + j]  = (now_keys[j] > LAST_SPECIAL) && !now_hit[j] &&
                                            (rom_now[j].code != 8'h00);
      evt_press[NUM_MODS + KEY_SLOTS + j] = 1'b1;
      evt_ext[NUM_MODS + KEY_SLOTS + j]   = rom_now[j].ext;
      evt_code[8*(NUM_MODS + KEY_SLOTS + j) +: 8] = rom_now[j].code;
    end
  end

  // hold state across short reports
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mods_r <= '0;
      for (int j = 0; j < KEY_SLOTS; j++) prev_keys_r[j] <= '0;
    end else if (accept && len_ok) begin
      prev_mods_r <= in_ch.modifier_bits;
      for (int j = 0; j < KEY_SLOTS; j++) prev_keys_r[j] <= now_keys[j];
    end
  end

endmodule

// ----- rtl/hbk_queue.sv -----
// hbk_queue: two-entry queue of classified reports between front and back.
// Depends on nothing but its width parameter.
module hbk_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  logic [1:0]       cnt_r;
  logic [WIDTH-1:0] head_r;
  logic [WIDTH-1:0] tail_r;
  logic             push;
  logic             pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = head_r;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (cnt_r == 2'd0) head_r <= wr_data;
      else               tail_r <= wr_data;
    end else if (pop && !push) begin
      head_r <= tail_r;
    end else if (push && pop) begin
      if (cnt_r == 2'd1) begin
        head_r <= wr_data;
      end else begin
        head_r <= tail_r;
        tail_r <= wr_data;
      end
    end
  end

endmodule

// ----- rtl/hbk_back.sv -----
// hbk_back: walks the event mask of one report, lowest event first, and sends
// one scancode byte per transfer through an output register. Depends on hbk_pkg, hbk_if.
module hbk_back #(
  parameter  int KEY_SLOTS = 6,
  localparam int NUM_EVT   = 8 + 2 * KEY_SLOTS,
  localparam int SEL_W     = $clog2(NUM_EVT)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  logic [NUM_EVT-1:0]   evt_mask,
  input  logic [NUM_EVT-1:0]   evt_press,
  input  logic [NUM_EVT-1:0]   evt_ext,
  input  logic [NUM_EVT*8-1:0] evt_code,
  hbk_out_if.source            out_ch
);
  import hbk_pkg::*;

  logic                 cur_valid_r;
  logic                 pre_done_r;
  logic [NUM_EVT-1:0]   cur_mask_r;
  logic [NUM_EVT-1:0]   cur_press_r;
  logic [NUM_EVT-1:0]   cur_ext_r;
  logic [NUM_EVT*8-1:0] cur_code_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;
  logic [SEL_W-1:0]     sel;
  logic [NUM_EVT-1:0]   rest;
  logic [7:0]           sel_code;
  logic                 out_free;
  logic                 emit;
  logic                 send_prefix;

  always_comb begin
    sel = '0;
    for (int i = NUM_EVT - 1; i >= 0; i--) begin
      if (cur_mask_r[i]) sel = SEL_W'(i);
    end
  end

  assign rest        = cur_mask_r & (cur_mask_r - NUM_EVT'(1));
  assign sel_code    = cur_code_r[8*sel +: 8];
  assign out_free    = !out_valid_r || out_ch.ready;
  assign emit        = cur_valid_r && out_free;
  assign send_prefix = cur_ext_r[sel] && !pre_done_r;
  assign pop_ready   = !cur_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      pre_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_valid && pop_ready) begin
        cur_valid_r <= 1'b1;
        pre_done_r  <= 1'b0;
      end else if (emit) begin
        if (send_prefix) begin
          pre_done_r <= 1'b1;
        end else begin
          pre_done_r <= 1'b0;
          if (rest == '0) cur_valid_r <= 1'b0;
        end
      end
      if (emit)              out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur_mask_r  <= evt_mask;
      cur_press_r <= evt_press;
      cur_ext_r   <= evt_ext;
      cur_code_r  <= evt_code;
    end else if (emit && !send_prefix) begin
      cur_mask_r <= rest;
    end
    if (emit) begin
      if (send_prefix) begin
        out_byte_r <= PREFIX_BYTE;
        out_last_r <= 1'b0;
      end else begin
        out_byte_r <= cur_press_r[sel] ? sel_code : (sel_code | BREAK_BIT);
        out_last_r <= (rest == '0);
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.scan_byte      = out_byte_r;
  assign out_ch.last_of_report = out_last_r;

endmodule
